FILE: rtl/core/uvs_pkg.sv
// Shared types, constants and elaboration-time tables for the UV-sphere tessellator.
// Depends on nothing; every other file refers to it by scoped names.
package uvs_pkg;

  // Angle format and division limits.
  localparam int ANGLE_BITS    = 16;
  localparam int MAX_DIVISIONS = 256;
  localparam int CNT_W         = 9;
  localparam int RAD_W         = 23;
  localparam int CORNER_W      = 17;
  localparam int POS_W         = 24;
  localparam int NORM_W        = 16;

  // Trig tables split a quarter-turn angle into a coarse and a fine part.
  localparam int TBL_BITS  = 7;
  localparam int TBL_DEPTH = 1 << TBL_BITS;
  localparam int TRIG_W    = 32;

  // One angle step of 2^-16 turn in radians.
  localparam real STEP_RAD = 3.14159265358979323846 / 32768.0;

  // Reciprocals for the angle quotients: ceil(2^RECIP_SHIFT / d).
  localparam int RECIP_SHIFT = 33;
  localparam int RECIP_W     = RECIP_SHIFT + 1;
  localparam int NUM_W       = 25;

  typedef enum logic {
    OP_VERTEX = 1'b0,
    OP_QUAD   = 1'b1
  } op_t;

  typedef enum logic {
    KIND_VERTEX   = 1'b0,
    KIND_TRIANGLE = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    REG_RADIUS  = 2'd0,
    REG_STACKS  = 2'd1,
    REG_SECTORS = 2'd2
  } reg_idx_t;

  // Per-item control that travels alongside the arithmetic.
  typedef struct packed {
    op_t                 op;
    logic                bad;
    logic                tri_a;
    logic                tri_b;
    logic [CORNER_W-1:0] k1;
    logic [CORNER_W-1:0] k2;
  } meta_t;

  typedef logic [TRIG_W-1:0]  trig_tbl_t  [TBL_DEPTH];
  typedef logic [RECIP_W-1:0] recip_tbl_t [MAX_DIVISIONS];

  // Sine or cosine in unsigned Q1.31 of n * 2^step_log quarter-turn steps of 2^-14.
  function automatic trig_tbl_t make_trig(input int step_log, input bit use_cos);
    trig_tbl_t t;
    real       th;
    real       v;
    for (int n = 0; n < TBL_DEPTH; n++) begin
      th   = real'(n) * (2.0 ** step_log) * STEP_RAD;
      v    = (use_cos ? $cos(th) : $sin(th)) * 2147483648.0;
      t[n] = TRIG_W'(longint'(v));
    end
    return t;
  endfunction

  // Entry d holds ceil(2^RECIP_SHIFT / (d+1)), found by restoring long division.
  function automatic recip_tbl_t make_recip();
    recip_tbl_t t;
    longint     num;
    longint     rem;
    longint     quo;
    for (int d = 0; d < MAX_DIVISIONS; d++) begin
      num = (longint'(1) <<< RECIP_SHIFT) + longint'(d);
      rem = 0;
      quo = 0;
      for (int b = RECIP_SHIFT; b >= 0; b--) begin
        rem = (rem <<< 1) | ((num >>> b) & longint'(1));
        quo = quo <<< 1;
        if (rem >= longint'(d + 1)) begin
          rem = rem - longint'(d + 1);
          quo = quo | longint'(1);
        end
      end
      t[d] = RECIP_W'(quo);
    end
    return t;
  endfunction

endpackage

FILE: rtl/core/uv_sphere_tessellator.sv
// Top level of the fixed-point UV-sphere tessellator: eight-stage pipeline.
// Depends on uvs_pkg for types, constants and the trig and reciprocal tables.
//
//  channel   | signals                                   | handshake
//  ----------+-------------------------------------------+---------------------------
//  request   | op, stack_index, sector_index             | start high, busy low
//  result    | kind, pos_*, norm_*, *_corner, last, bad  | done strobe, one cycle
//  config    | cfg_index, cfg_data                       | cfg_valid and cfg_ready
//
// One item enters per cycle while busy is low; its first result is on the ports when the
// item reaches stage 8, the output stage.
// A quad item with two triangles occupies the output stage until both are out, and busy is
// high while its first triangle is shown and the whole pipeline holds.
// Reset (rst, synchronous) empties the pipeline and loads radius 1.0, 20 stacks and
// 20 sectors. Results cannot be held off by the receiver.
module uv_sphere_tessellator (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic                            op,
  input  logic [uvs_pkg::CNT_W-1:0]       stack_index,
  input  logic [uvs_pkg::CNT_W-1:0]       sector_index,
  output logic                            done,
  output logic                            kind,
  output logic signed [uvs_pkg::POS_W-1:0]  pos_x,
  output logic signed [uvs_pkg::POS_W-1:0]  pos_y,
  output logic signed [uvs_pkg::POS_W-1:0]  pos_z,
  output logic signed [uvs_pkg::NORM_W-1:0] norm_x,
  output logic signed [uvs_pkg::NORM_W-1:0] norm_y,
  output logic signed [uvs_pkg::NORM_W-1:0] norm_z,
  output logic [uvs_pkg::CORNER_W-1:0]    first_corner,
  output logic [uvs_pkg::CORNER_W-1:0]    second_corner,
  output logic [uvs_pkg::CORNER_W-1:0]    third_corner,
  output logic                            last,
  output logic                            bad,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [1:0]                      cfg_index,
  input  logic [uvs_pkg::RAD_W-1:0]       cfg_data
);

  localparam int CW = uvs_pkg::CNT_W;
  localparam int KW = uvs_pkg::CORNER_W;
  localparam int TW = uvs_pkg::TRIG_W;
  localparam int TB = uvs_pkg::TBL_BITS;
  localparam int NW = uvs_pkg::NUM_W;
  localparam int RW = uvs_pkg::RECIP_W;
  localparam int PW = NW + RW;
  localparam int QW = uvs_pkg::ANGLE_BITS + 1;
  localparam int AB = uvs_pkg::ANGLE_BITS;

  localparam uvs_pkg::trig_tbl_t  SIN_HI = uvs_pkg::make_trig(TB, 1'b0);
  localparam uvs_pkg::trig_tbl_t  COS_HI = uvs_pkg::make_trig(TB, 1'b1);
  localparam uvs_pkg::trig_tbl_t  SIN_LO = uvs_pkg::make_trig(0, 1'b0);
  localparam uvs_pkg::trig_tbl_t  COS_LO = uvs_pkg::make_trig(0, 1'b1);
  localparam uvs_pkg::recip_tbl_t RECIP  = uvs_pkg::make_recip();

  // Sine and cosine of a full-turn angle from first-quadrant values, packed {s, c}.
  function automatic logic [31:0] quad_map(input logic [1:0] q, input logic [15:0] sr,
                                           input logic [15:0] cr);
    logic [31:0] r;
    case (q)
      2'd0:    r = {sr, cr};
      2'd1:    r = {cr, 16'(-cr + cr - sr)};
      2'd2:    r = {16'(-sr), 16'(-cr)};
      default: r = {16'(-cr), sr};
    endcase
    return r;
  endfunction

  // round(p / 2^14), halves away from zero.
  function automatic logic signed [39:0] scale_round(input logic signed [39:0] p);
    logic [39:0] m;
    m = p[39] ? 40'(-p) : 40'(p);
    m = (m + 40'd8192) >> 14;
    return p[39] ? -$signed(m) : $signed(m);
  endfunction

  // Configuration registers.
  logic [uvs_pkg::RAD_W-1:0] radius;
  logic [CW-1:0]             stack_count;
  logic [CW-1:0]             sector_count;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius       <= uvs_pkg::RAD_W'(65536);
      stack_count  <= CW'(20);
      sector_count <= CW'(20);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        uvs_pkg::REG_RADIUS:  radius       <= cfg_data;
        uvs_pkg::REG_STACKS:  stack_count  <= cfg_data[CW-1:0];
        uvs_pkg::REG_SECTORS: sector_count <= cfg_data[CW-1:0];
        default: ;
      endcase
    end
  end

  // Effective counts, clamped to the largest supported division.
  logic [CW-1:0] st_eff;
  logic [CW-1:0] se_eff;
  assign st_eff = (stack_count > CW'(uvs_pkg::MAX_DIVISIONS)) ?
                  CW'(uvs_pkg::MAX_DIVISIONS) : stack_count;
  assign se_eff = (sector_count > CW'(uvs_pkg::MAX_DIVISIONS)) ?
                  CW'(uvs_pkg::MAX_DIVISIONS) : sector_count;

  // Pipeline registers.
  logic                 v1, v2, v3, v4, v5, v6, v7, v8;
  logic                 phase;
  logic                 stall;
  uvs_pkg::op_t         op1;
  logic [CW-1:0]        i1, j1;
  uvs_pkg::meta_t       m2, m3, m4, m5, m6, m7, m8;
  logic [NW-1:0]        nlat2, nlon2;
  logic [RW-1:0]        rlat2, rlon2;
  logic [QW-1:0]        qlat3, qlon3;
  logic [1:0]           qd_lat4, qd_lon4, qd_lat5, qd_lon5;
  logic [TW-1:0]        lat_sh4, lat_ch4, lat_sl4, lat_cl4;
  logic [TW-1:0]        lon_sh4, lon_ch4, lon_sl4, lon_cl4;
  logic [2*TW-1:0]      lat_a5, lat_b5, lat_c5, lat_d5;
  logic [2*TW-1:0]      lon_a5, lon_b5, lon_c5, lon_d5;
  logic signed [15:0]   sl6, cl6, so6, co6;
  logic signed [15:0]   nx7, ny7, nz7, nx8, ny8, nz8;
  logic signed [23:0]   px8, py8, pz8;

  // Stage 1 decode: range check, triangle corners and quotient numerators.
  uvs_pkg::meta_t       m1d;
  logic [KW-1:0]        k1d;
  logic [NW-1:0]        nlat_d, nlon_d;
  always_comb begin
    k1d        = KW'(i1) * (KW'(se_eff) + KW'(1)) + KW'(j1);
    m1d.op     = op1;
    m1d.bad    = (st_eff == '0) || (se_eff == '0) ||
                 (op1 == uvs_pkg::OP_VERTEX && (i1 > st_eff || j1 > se_eff)) ||
                 (op1 == uvs_pkg::OP_QUAD && (i1 >= st_eff || j1 >= se_eff));
    m1d.tri_a  = (i1 != '0);
    m1d.tri_b  = (i1 != st_eff - CW'(1));
    m1d.k1     = k1d;
    m1d.k2     = k1d + KW'(se_eff) + KW'(1);
    nlat_d     = (NW'(i1) << (AB - 1)) + NW'(st_eff >> 1);
    nlon_d     = (NW'(j1) << AB) + NW'(se_eff >> 1);
  end

  // Stage 2 quotients: numerator times reciprocal, then drop the fraction.
  logic [PW-1:0] plat, plon;
  assign plat = PW'(nlat2) * PW'(rlat2);
  assign plon = PW'(nlon2) * PW'(rlon2);

  // Stage 3 angles and table look-ups.
  logic [AB-1:0] lat_a, lon_a;
  assign lat_a = AB'(QW'(1 << (AB - 2)) - qlat3);
  assign lon_a = qlon3[AB-1:0];

  // Stage 5 angle sums and rounding to Q1.14.
  logic [2*TW-1:0] lat_s, lat_c, lon_s, lon_c;
  logic [31:0]     lat_sc, lon_sc;
  always_comb begin
    lat_s  = lat_a5 + lat_b5 + (2*TW)'(64'd1 << 47);
    lat_c  = lat_c5 - lat_d5 + (2*TW)'(64'd1 << 47);
    lon_s  = lon_a5 + lon_b5 + (2*TW)'(64'd1 << 47);
    lon_c  = lon_c5 - lon_d5 + (2*TW)'(64'd1 << 47);
    lat_sc = quad_map(qd_lat5, lat_s[63:48], lat_c[63:48]);
    lon_sc = quad_map(qd_lon5, lon_s[63:48], lon_c[63:48]);
  end

  // Two-triangle quads hold the pipeline while their first triangle is in the output stage.
  logic quad_ok;
  assign quad_ok = (m8.op == uvs_pkg::OP_QUAD) && !m8.bad;
  assign stall   = v8 && quad_ok && m8.tri_a && m8.tri_b && !phase;
  assign busy    = stall;

  // Valid bits and the second-triangle phase.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0;
      v5 <= 1'b0; v6 <= 1'b0; v7 <= 1'b0; v8 <= 1'b0;
      phase <= 1'b0;
    end else begin
      phase <= stall;
      if (!stall) begin
        v1 <= start;
        v2 <= v1; v3 <= v2; v4 <= v3;
        v5 <= v4; v6 <= v5; v7 <= v6; v8 <= v7;
      end
    end
  end

  // Datapath registers, all advancing together unless the output stage holds.
  always_ff @(posedge clk) begin
    if (!stall) begin
      op1 <= uvs_pkg::op_t'(op);
      i1  <= stack_index;
      j1  <= sector_index;

      m2    <= m1d;
      nlat2 <= nlat_d;
      nlon2 <= nlon_d;
      rlat2 <= RECIP[st_eff[7:0] - 8'd1];
      rlon2 <= RECIP[se_eff[7:0] - 8'd1];

      m3    <= m2;
      qlat3 <= QW'(plat >> uvs_pkg::RECIP_SHIFT);
      qlon3 <= QW'(plon >> uvs_pkg::RECIP_SHIFT);

      m4      <= m3;
      qd_lat4 <= lat_a[AB-1:AB-2];
      qd_lon4 <= lon_a[AB-1:AB-2];
      lat_sh4 <= SIN_HI[lat_a[AB-3:TB]];
      lat_ch4 <= COS_HI[lat_a[AB-3:TB]];
      lat_sl4 <= SIN_LO[lat_a[TB-1:0]];
      lat_cl4 <= COS_LO[lat_a[TB-1:0]];
      lon_sh4 <= SIN_HI[lon_a[AB-3:TB]];
      lon_ch4 <= COS_HI[lon_a[AB-3:TB]];
      lon_sl4 <= SIN_LO[lon_a[TB-1:0]];
      lon_cl4 <= COS_LO[lon_a[TB-1:0]];

      m5      <= m4;
      qd_lat5 <= qd_lat4;
      qd_lon5 <= qd_lon4;
      lat_a5  <= (2*TW)'(lat_sh4) * (2*TW)'(lat_cl4);
      lat_b5  <= (2*TW)'(lat_ch4) * (2*TW)'(lat_sl4);
      lat_c5  <= (2*TW)'(lat_ch4) * (2*TW)'(lat_cl4);
      lat_d5  <= (2*TW)'(lat_sh4) * (2*TW)'(lat_sl4);
      lon_a5  <= (2*TW)'(lon_sh4) * (2*TW)'(lon_cl4);
      lon_b5  <= (2*TW)'(lon_ch4) * (2*TW)'(lon_sl4);
      lon_c5  <= (2*TW)'(lon_ch4) * (2*TW)'(lon_cl4);
      lon_d5  <= (2*TW)'(lon_sh4) * (2*TW)'(lon_sl4);

      m6  <= m5;
      sl6 <= $signed(lat_sc[31:16]);
      cl6 <= $signed(lat_sc[15:0]);
      so6 <= $signed(lon_sc[31:16]);
      co6 <= $signed(lon_sc[15:0]);

      m7  <= m6;
      nx7 <= 16'(scale_round(40'(cl6) * 40'(co6)));
      ny7 <= sl6;
      nz7 <= 16'(scale_round(40'(cl6) * 40'(so6)));

      m8  <= m7;
      nx8 <= nx7;
      ny8 <= ny7;
      nz8 <= nz7;
      px8 <= 24'(scale_round(40'($signed({1'b0, radius})) * 40'(nx7)));
      py8 <= 24'(scale_round(40'($signed({1'b0, radius})) * 40'(ny7)));
      pz8 <= 24'(scale_round(40'($signed({1'b0, radius})) * 40'(nz7)));
    end
  end

  // Result selection from the output stage.
  logic vert_ok;
  logic use_b;
  assign vert_ok = (m8.op == uvs_pkg::OP_VERTEX) && !m8.bad;
  assign use_b   = !m8.tri_a || phase;

  assign done          = v8 && (!quad_ok || m8.tri_a || m8.tri_b);
  assign kind          = quad_ok ? uvs_pkg::KIND_TRIANGLE : uvs_pkg::KIND_VERTEX;
  assign pos_x         = vert_ok ? px8 : '0;
  assign pos_y         = vert_ok ? py8 : '0;
  assign pos_z         = vert_ok ? pz8 : '0;
  assign norm_x        = vert_ok ? nx8 : '0;
  assign norm_y        = vert_ok ? ny8 : '0;
  assign norm_z        = vert_ok ? nz8 : '0;
  assign first_corner  = !quad_ok ? '0 : (use_b ? m8.k1 + KW'(1) : m8.k1);
  assign second_corner = !quad_ok ? '0 : m8.k2;
  assign third_corner  = !quad_ok ? '0 : (use_b ? m8.k2 + KW'(1) : m8.k1 + KW'(1));
  assign last          = !(quad_ok && m8.tri_a && m8.tri_b && !phase);
  assign bad           = m8.bad;

  // A held output stage always finishes its item in the following cycle.
  a_hold_then_last: assert property (@(posedge clk) disable iff (rst)
    busy |=> done && last && kind == uvs_pkg::KIND_TRIANGLE)
    else $error("second triangle did not follow a hold");

  // A result that is not the last of its item is followed at once by the last one.
  a_pair: assert property (@(posedge clk) disable iff (rst)
    done && !last |=> done && last)
    else $error("result pair broken");

  // An out-of-range item carries nothing but its flags.
  a_bad_clean: assert property (@(posedge clk) disable iff (rst)
    done && bad |-> last && kind == uvs_pkg::KIND_VERTEX && pos_x == '0 &&
                    norm_y == '0 && first_corner == '0 && third_corner == '0)
    else $error("bad result carries data");

  // The x and y normal components of a vertex stay within plus or minus one.
  a_norm_range: assert property (@(posedge clk) disable iff (rst)
    done && !bad && kind == uvs_pkg::KIND_VERTEX |->
      norm_y <= 16'sd16384 && norm_y >= -16'sd16384 &&
      norm_x <= 16'sd16384 && norm_x >= -16'sd16384)
    else $error("normal out of range");

endmodule
